// ===== rtl/core/segi_pkg.sv =====
package segi_pkg;

    // coordinate, difference, product and magnitude widths
    localparam int CW = 24;
    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int WA = PW + 1;

    // parameter result width and saturation limits
    localparam int QW = 19;
    localparam logic signed [QW-1:0] PAR_MAX = {1'b0, {(QW-1){1'b1}}};
    localparam logic signed [QW-1:0] PAR_MIN = {1'b1, {(QW-1){1'b0}}};

    // coordinate saturation limits
    localparam logic signed [CW-1:0] CRD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CRD_MIN = {1'b1, {(CW-1){1'b0}}};

    typedef logic signed [CW-1:0] t_crd;
    typedef logic signed [DW-1:0] t_diff;
    typedef logic signed [PW-1:0] t_prod;
    typedef logic signed [WA-1:0] t_cross;
    typedef logic [WA-1:0] t_mag;

endpackage

// ===== rtl/core/segi_div.sv =====
module segi_div import segi_pkg::*; #(
    parameter int PFB = 16
) (
    input  logic                 i_clk,
    input  logic [QW+1:0]        i_en,
    input  t_mag                 i_num,
    input  t_mag                 i_den,
    input  logic                 i_neg,
    output logic signed [QW-1:0] o_quo
);

    localparam int SH = (PFB > QW) ? PFB : QW;
    localparam int WR = WA + SH;

    logic [WR-1:0] num_sh;
    logic [WR-1:0] den_sh;

    logic [WR-1:0] r_rem [0:QW];
    t_mag          r_den [0:QW-1];
    logic [QW-1:0] r_q   [0:QW];
    logic          r_neg [0:QW];
    logic          r_ovf [0:QW];

    // scaled numerator and overflow check against den * 2^QW
    assign num_sh = WR'(i_num) << PFB;
    assign den_sh = WR'(i_den) << QW;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_rem[0] <= num_sh;
            r_den[0] <= i_den;
            r_q[0]   <= '0;
            r_neg[0] <= i_neg;
            r_ovf[0] <= (num_sh >= den_sh);
        end
    end

    // one quotient bit per stage, msb first
    for (genvar k = 1; k <= QW; k++) begin : g_step
        localparam int B = QW - k;
        logic [WR-1:0] den_k;
        logic          ge;
        logic [QW-1:0] q_n;

        assign den_k = WR'(r_den[k-1]) << B;
        assign ge    = (r_rem[k-1] >= den_k);

        always_comb begin
            q_n    = r_q[k-1];
            q_n[B] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_rem[k] <= ge ? (r_rem[k-1] - den_k) : r_rem[k-1];
                r_q[k]   <= q_n;
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end

        if (k < QW) begin : g_den
            always_ff @(posedge i_clk) begin
                if (i_en[k]) begin
                    r_den[k] <= r_den[k-1];
                end
            end
        end
    end

    // sign, floor toward minus infinity and saturation
    logic          nz;
    logic [QW:0]   mag;
    logic signed [QW-1:0] n_quo;

    assign nz  = |r_rem[QW];
    assign mag = {1'b0, r_q[QW]} + (QW+1)'(nz);

    always_comb begin
        if (r_ovf[QW]) begin
            n_quo = r_neg[QW] ? PAR_MIN : PAR_MAX;
        end else if (!r_neg[QW]) begin
            n_quo = r_q[QW][QW-1] ? PAR_MAX : $signed(r_q[QW]);
        end else if (mag > (QW+1)'({1'b1, {(QW-1){1'b0}}})) begin
            n_quo = PAR_MIN;
        end else begin
            n_quo = $signed(QW'((~mag) + (QW+1)'(1)));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[QW+1]) begin
            o_quo <= n_quo;
        end
    end

endmodule

// ===== rtl/core/segment_intersection_unit.sv =====
// Segment intersection: each request carries a ray segment and a wall segment in signed
// fixed point and returns hit, parallel, the ray parameter t, the wall parameter and the
// intersection point. The block is a 27-stage pipeline that takes one request per cycle
// while o_ready is high and returns one result per request, in order. Most stages belong
// to the two restoring dividers, which resolve one quotient bit per stage; the remaining
// stages hold the difference, cross-product, magnitude, point multiply and output
// register steps. Every stage has its own valid bit and a stage loads whenever it is
// empty or its successor moves, so bubbles close up and requests keep entering while
// a result waits at the output until every stage holds a request; only then does
// o_ready drop.
module segment_intersection_unit import segi_pkg::*; #(
    parameter int COORD_FRAC_BITS = 8,
    parameter int PARAM_FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_crd                 i_ray_start_x,
    input  t_crd                 i_ray_start_y,
    input  t_crd                 i_ray_end_x,
    input  t_crd                 i_ray_end_y,
    input  t_crd                 i_wall_start_x,
    input  t_crd                 i_wall_start_y,
    input  t_crd                 i_wall_end_x,
    input  t_crd                 i_wall_end_y,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_hit,
    output logic                 o_parallel,
    output logic signed [QW-1:0] o_ray_param,
    output logic signed [QW-1:0] o_wall_param,
    output t_crd                 o_point_x,
    output t_crd                 o_point_y
);

    // stage map: 0 differences, 1 products, 2 cross terms, 3 magnitudes and tests,
    // 4 .. 4+NDS-1 dividers, then point multiply and output register
    localparam int NDS = QW + 2;
    localparam int SD  = 4;
    localparam int SP  = SD + NDS;
    localparam int NS  = SP + 2;

    // |d| * 500000 < 2^(2*frac) reduces to |d| below this bound
    localparam longint unsigned ONE_SQ = 64'd1 << (2 * COORD_FRAC_BITS);
    localparam longint unsigned PAR_TH_L = (ONE_SQ + 64'd499999) / 64'd500000;
    localparam t_mag PAR_TH = WA'(PAR_TH_L);

    localparam int MW = QW + DW;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] en;

    // a stage moves when empty or when the one after it moves
    assign en[NS-1] = !r_vld[NS-1] || i_ready;
    for (genvar s = 0; s < NS - 1; s++) begin : g_en
        assign en[s] = !r_vld[s] || en[s+1];
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // stage 0: coordinate differences
    t_diff r_a, r_b, r_c, r_e, r_f, r_g, r_dx0, r_dy0;
    t_crd  r_x10, r_y10;

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_a   <= DW'(i_ray_start_x) - DW'(i_ray_end_x);
            r_b   <= DW'(i_wall_start_y) - DW'(i_wall_end_y);
            r_c   <= DW'(i_ray_start_y) - DW'(i_ray_end_y);
            r_e   <= DW'(i_wall_start_x) - DW'(i_wall_end_x);
            r_f   <= DW'(i_ray_start_x) - DW'(i_wall_start_x);
            r_g   <= DW'(i_ray_start_y) - DW'(i_wall_start_y);
            r_dx0 <= DW'(i_ray_end_x) - DW'(i_ray_start_x);
            r_dy0 <= DW'(i_ray_end_y) - DW'(i_ray_start_y);
            r_x10 <= i_ray_start_x;
            r_y10 <= i_ray_start_y;
        end
    end

    // stage 1: six cross products
    t_prod r_ab, r_ce, r_fb, r_ge, r_ag, r_cf;
    t_diff r_dx1, r_dy1;
    t_crd  r_x11, r_y11;

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_ab  <= r_a * r_b;
            r_ce  <= r_c * r_e;
            r_fb  <= r_f * r_b;
            r_ge  <= r_g * r_e;
            r_ag  <= r_a * r_g;
            r_cf  <= r_c * r_f;
            r_dx1 <= r_dx0;
            r_dy1 <= r_dy0;
            r_x11 <= r_x10;
            r_y11 <= r_y10;
        end
    end

    // stage 2: denominator and both numerators
    t_cross r_d, r_tn, r_un;
    t_diff  r_dx2, r_dy2;
    t_crd   r_x12, r_y12;

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_d   <= WA'(r_ab) - WA'(r_ce);
            r_tn  <= WA'(r_fb) - WA'(r_ge);
            r_un  <= WA'(r_cf) - WA'(r_ag);
            r_dx2 <= r_dx1;
            r_dy2 <= r_dy1;
            r_x12 <= r_x11;
            r_y12 <= r_y11;
        end
    end

    // stage 3: magnitudes, quotient signs, exact unit-range test, parallel test
    logic in_t, in_w;
    t_mag abs_d;

    assign abs_d = r_d[WA-1] ? t_mag'(-r_d) : t_mag'(r_d);

    always_comb begin
        if (r_d > 0) begin
            in_t = (r_tn >= 0) && (r_tn <= r_d);
            in_w = (r_un >= 0) && (r_un <= r_d);
        end else begin
            in_t = (r_tn <= 0) && (r_tn >= r_d);
            in_w = (r_un <= 0) && (r_un >= r_d);
        end
    end

    t_mag  r_ad, r_atn, r_aun;
    logic  r_neg_t, r_neg_w, r_hit3, r_par3;
    t_diff r_dx3, r_dy3;
    t_crd  r_x13, r_y13;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_ad    <= abs_d;
            r_atn   <= r_tn[WA-1] ? t_mag'(-r_tn) : t_mag'(r_tn);
            r_aun   <= r_un[WA-1] ? t_mag'(-r_un) : t_mag'(r_un);
            r_neg_t <= r_tn[WA-1] ^ r_d[WA-1];
            r_neg_w <= r_un[WA-1] ^ r_d[WA-1];
            r_hit3  <= in_t && in_w;
            r_par3  <= (abs_d < PAR_TH);
            r_dx3   <= r_dx2;
            r_dy3   <= r_dy2;
            r_x13   <= r_x12;
            r_y13   <= r_y12;
        end
    end

    // stages 4 .. SP-1: the two dividers
    logic signed [QW-1:0] quo_t, quo_w;

    segi_div #(
        .PFB (PARAM_FRAC_BITS)
    ) u_div_t (
        .i_clk (i_clk),
        .i_en  (en[SP-1:SD]),
        .i_num (r_atn),
        .i_den (r_ad),
        .i_neg (r_neg_t),
        .o_quo (quo_t)
    );

    segi_div #(
        .PFB (PARAM_FRAC_BITS)
    ) u_div_w (
        .i_clk (i_clk),
        .i_en  (en[SP-1:SD]),
        .i_num (r_aun),
        .i_den (r_ad),
        .i_neg (r_neg_w),
        .o_quo (quo_w)
    );

    // side data riding along with the dividers
    logic  r_sb_hit [0:NDS-1];
    logic  r_sb_par [0:NDS-1];
    t_diff r_sb_dx  [0:NDS-1];
    t_diff r_sb_dy  [0:NDS-1];
    t_crd  r_sb_x1  [0:NDS-1];
    t_crd  r_sb_y1  [0:NDS-1];

    always_ff @(posedge i_clk) begin
        if (en[SD]) begin
            r_sb_hit[0] <= r_hit3;
            r_sb_par[0] <= r_par3;
            r_sb_dx[0]  <= r_dx3;
            r_sb_dy[0]  <= r_dy3;
            r_sb_x1[0]  <= r_x13;
            r_sb_y1[0]  <= r_y13;
        end
    end

    for (genvar j = 1; j < NDS; j++) begin : g_sb
        always_ff @(posedge i_clk) begin
            if (en[SD+j]) begin
                r_sb_hit[j] <= r_sb_hit[j-1];
                r_sb_par[j] <= r_sb_par[j-1];
                r_sb_dx[j]  <= r_sb_dx[j-1];
                r_sb_dy[j]  <= r_sb_dy[j-1];
                r_sb_x1[j]  <= r_sb_x1[j-1];
                r_sb_y1[j]  <= r_sb_y1[j-1];
            end
        end
    end

    // point multiply: t times ray delta
    logic signed [MW-1:0] r_mx, r_my;
    logic signed [QW-1:0] r_t5, r_w5;
    logic                 r_hit5, r_par5;
    t_crd                 r_x15, r_y15;

    always_ff @(posedge i_clk) begin
        if (en[SP]) begin
            r_mx   <= MW'(quo_t) * MW'(r_sb_dx[NDS-1]);
            r_my   <= MW'(quo_t) * MW'(r_sb_dy[NDS-1]);
            r_t5   <= quo_t;
            r_w5   <= quo_w;
            r_hit5 <= r_sb_hit[NDS-1];
            r_par5 <= r_sb_par[NDS-1];
            r_x15  <= r_sb_x1[NDS-1];
            r_y15  <= r_sb_y1[NDS-1];
        end
    end

    // floor shift, add start point and clamp to the coordinate range
    logic signed [MW:0] sum_x, sum_y;
    t_crd               n_px, n_py;

    assign sum_x = (MW+1)'(r_x15) + (MW+1)'(r_mx >>> PARAM_FRAC_BITS);
    assign sum_y = (MW+1)'(r_y15) + (MW+1)'(r_my >>> PARAM_FRAC_BITS);

    always_comb begin
        if (sum_x > (MW+1)'(CRD_MAX)) begin
            n_px = CRD_MAX;
        end else if (sum_x < (MW+1)'(CRD_MIN)) begin
            n_px = CRD_MIN;
        end else begin
            n_px = CW'(sum_x);
        end
        if (sum_y > (MW+1)'(CRD_MAX)) begin
            n_py = CRD_MAX;
        end else if (sum_y < (MW+1)'(CRD_MIN)) begin
            n_py = CRD_MIN;
        end else begin
            n_py = CW'(sum_y);
        end
    end

    // output register, parallel segments report zeros
    always_ff @(posedge i_clk) begin
        if (en[NS-1]) begin
            o_parallel   <= r_par5;
            o_hit        <= r_par5 ? 1'b0 : r_hit5;
            o_ray_param  <= r_par5 ? '0 : r_t5;
            o_wall_param <= r_par5 ? '0 : r_w5;
            o_point_x    <= r_par5 ? '0 : n_px;
            o_point_y    <= r_par5 ? '0 : n_py;
        end
    end

`ifndef SYNTHESIS
    // parallel result carries nothing else
    a_par_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_parallel |-> !o_hit && o_ray_param == '0 && o_wall_param == '0)
        else $error("parallel result with nonzero fields");

    // a hit means both parameters lie in the unit range, so neither is ever negative
    a_hit_t_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> !o_ray_param[QW-1] && !o_wall_param[QW-1])
        else $error("hit with negative parameter");

    // a stalled result stays in the output stage
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("stalled result dropped");

    // an empty output stage never blocks the stages behind it
    a_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[NS-1] |-> en[NS-2])
        else $error("pipeline blocked behind an empty output stage");
`endif

endmodule
